// ----- rtl/core/sapq_pkg.sv -----
// ----------------------------------------------------------------------------
// sapq_pkg
// Types and codes shared by the sorted-array priority queue and its cells.
// ----------------------------------------------------------------------------
package sapq_pkg;

  localparam int unsigned KEY_W = 32;
  localparam int unsigned OCC_W = 5;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_t;

  typedef enum logic {
    ACT_INSERT = 1'b0,
    ACT_DELETE = 1'b1
  } action_t;

  typedef logic signed [KEY_W-1:0] key_t;

  // broadcast to every cell in the row
  typedef struct packed {
    logic ins;
    logic del;
    key_t new_key;
  } cell_ctrl_t;

endpackage

// ----- rtl/core/sapq_cell.sv -----
// ----------------------------------------------------------------------------
// sapq_cell
// One slot of the sorted row: compares its key against the incoming key and
// takes its left or right neighbor's key or the new key, or keeps its own.
// ----------------------------------------------------------------------------
module sapq_cell
  import sapq_pkg::*;
(
  input  logic       clk,
  input  cell_ctrl_t ctrl,
  input  logic       occ,
  input  logic       tail,
  input  key_t       prev_key,
  input  logic       prev_gt,
  input  key_t       next_key,
  output key_t       key_o,
  output logic       gt_o
);

  key_t key_r;
  key_t key_nxt;
  logic gt;

  assign gt    = occ && (key_r > ctrl.new_key);
  assign gt_o  = gt;
  assign key_o = key_r;

  always_comb begin
    key_nxt = key_r;
    if (ctrl.ins) begin
      if (prev_gt) begin
        key_nxt = prev_key;
      end else if (gt || tail) begin
        key_nxt = ctrl.new_key;
      end
    end else if (ctrl.del) begin
      key_nxt = next_key;
    end
  end

  always_ff @(posedge clk) begin
    key_r <= key_nxt;
  end

endmodule

// ----- rtl/core/sorted_array_min_priority_queue.sv -----
// ----------------------------------------------------------------------------
// sorted_array_min_priority_queue
// Min-priority queue of up to DEPTH signed keys held in ascending order in a
// row of compare-and-shift cells.
// ----------------------------------------------------------------------------
// Each transaction is an insert or a delete-min and yields one result with a
// status, the removed key and the occupancy. Every cell compares its key with
// the incoming key in parallel and shifts at once, so one transaction is taken
// per cycle while the result side keeps up; the registered result appears in
// the cycle after acceptance, the next transaction is taken in the cycle that
// result is accepted, and the input stalls for as long as the result waits.
// Equal keys leave in the order they arrived. An insert into a full queue and
// a delete from an empty one leave the queue unchanged and report their status.
module sorted_array_min_priority_queue
  import sapq_pkg::*;
#(
  parameter int unsigned DEPTH = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        in_action,
  input  key_t        in_key,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  out_status,
  output key_t        out_removed_key,
  output logic [OCC_W-1:0] out_occupancy
);

  localparam int unsigned CW = $clog2(DEPTH + 1);

  logic [CW-1:0]    count_r;
  logic [CW-1:0]    count_nxt;
  logic             out_valid_r;
  logic             out_valid_nxt;
  status_t          status_r;
  status_t          status_nxt;
  key_t             removed_r;
  key_t             removed_nxt;
  logic [OCC_W-1:0] occ_r;
  logic             accept;
  logic             full;
  logic             empty;
  cell_ctrl_t       ctrl;
  key_t             keys [DEPTH];
  logic             gts  [DEPTH];

  assign full     = (count_r == CW'(DEPTH));
  assign empty    = (count_r == '0);
  assign in_ready = !out_valid_r || out_ready;
  assign accept   = in_valid && in_ready;

  assign ctrl.ins     = accept && (in_action == ACT_INSERT) && !full;
  assign ctrl.del     = accept && (in_action == ACT_DELETE) && !empty;
  assign ctrl.new_key = in_key;

  genvar i;
  generate
    for (i = 0; i < DEPTH; i++) begin : g_cell
      key_t prev_key;
      logic prev_gt;
      key_t next_key;
      if (i == 0) begin : g_first
        assign prev_key = keys[0];
        assign prev_gt  = 1'b0;
      end else begin : g_mid
        assign prev_key = keys[i-1];
        assign prev_gt  = gts[i-1];
      end
      if (i == DEPTH - 1) begin : g_last
        assign next_key = keys[i];
      end else begin : g_inner
        assign next_key = keys[i+1];
      end
      sapq_cell u_cell (
        .clk      (clk),
        .ctrl     (ctrl),
        .occ      (CW'(i) < count_r),
        .tail     (CW'(i) == count_r),
        .prev_key (prev_key),
        .prev_gt  (prev_gt),
        .next_key (next_key),
        .key_o    (keys[i]),
        .gt_o     (gts[i])
      );
    end
  endgenerate

  always_comb begin
    count_nxt     = count_r;
    out_valid_nxt = out_valid_r && !out_ready;
    status_nxt    = status_r;
    removed_nxt   = removed_r;
    if (accept) begin
      out_valid_nxt = 1'b1;
      removed_nxt   = '0;
      status_nxt    = ST_OK;
      if (in_action == ACT_INSERT) begin
        if (full) begin
          status_nxt = ST_FULL;
        end else begin
          count_nxt = count_r + 1'b1;
        end
      end else begin
        if (empty) begin
          status_nxt = ST_EMPTY;
        end else begin
          count_nxt   = count_r - 1'b1;
          removed_nxt = keys[0];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      status_r  <= status_nxt;
      removed_r <= removed_nxt;
      occ_r     <= OCC_W'(count_nxt);
    end
  end

  assign out_valid       = out_valid_r;
  assign out_status      = status_r;
  assign out_removed_key = removed_r;
  assign out_occupancy   = occ_r;

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(DEPTH))
    else $error("key count exceeds depth");

  a_empty_delete: assert property (@(posedge clk) disable iff (!rst_n)
    accept && (in_action == ACT_DELETE) && empty |=> (out_status == ST_EMPTY))
    else $error("delete on empty queue not reported");

  a_insert_count: assert property (@(posedge clk) disable iff (!rst_n)
    ctrl.ins |=> (count_r == $past(count_r) + 1'b1))
    else $error("insert did not advance count");

  a_head_order: assert property (@(posedge clk) disable iff (!rst_n)
    (count_r >= CW'(2)) |-> !(keys[0] > keys[1]))
    else $error("head keys out of order");
`endif

endmodule
